>>> hw/rtl/asv_pkg.sv
// Shared widths, register indexes and sideband types for the arrive steering unit.
// No dependencies.
`timescale 1ns / 1ps

package asv_pkg;

  localparam int POS_W    = 24;  // signed Q15.8 positions and velocities
  localparam int RAD_W    = 23;  // unsigned Q15.8 radii and speed
  localparam int DIFF_W   = 25;  // exact coordinate difference
  localparam int MAG_W    = 24;  // magnitude of a difference
  localparam int SUM_W    = 49;  // dx^2 + dy^2
  localparam int SQ_W     = 50;  // radicand padded to an even width
  localparam int DIST_W   = 25;  // integer square root
  localparam int SQREM_W  = 27;  // square root partial remainder
  localparam int NUM_W    = 46;  // ramp numerator
  localparam int PROD_W   = 48;  // component numerator
  localparam int VQ_W     = 24;  // component quotient
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd2;

  localparam logic [RAD_W-1:0] TARGET_RADIUS_RST = 23'd256;
  localparam logic [RAD_W-1:0] OUTER_RADIUS_RST  = 23'd2560;
  localparam logic [RAD_W-1:0] MAX_SPEED_RST     = 23'd25600;

  localparam logic [POS_W-1:0] VEL_MAX = 24'h7fffff;
  localparam logic [POS_W-1:0] VEL_MIN = 24'h800000;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } sq_side_t;

  typedef struct packed {
    logic              arrived;
    logic              full;
    logic              sx;
    logic              sy;
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    logic [DIST_W-1:0] dlen;
  } rd_side_t;

  typedef struct packed {
    logic             arrived;
    logic             sx;
    logic [RAD_W-1:0] spd;
  } vx_side_t;

endpackage

>>> hw/rtl/asv_if.sv
// Request channels of the arrive steering unit: positions in, steering out, register writes.
// Depends on asv_pkg.
`timescale 1ns / 1ps

interface asv_in_if import asv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] agent_x;
  logic [POS_W-1:0] agent_y;
  logic [POS_W-1:0] goal_x;
  logic [POS_W-1:0] goal_y;
  modport source (output valid, agent_x, agent_y, goal_x, goal_y, input ready);
  modport sink   (input valid, agent_x, agent_y, goal_x, goal_y, output ready);
endinterface

interface asv_out_if import asv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] velocity_x;
  logic [POS_W-1:0] velocity_y;
  logic [RAD_W-1:0] speed;
  logic             arrived;
  modport source (output valid, velocity_x, velocity_y, speed, arrived, input ready);
  modport sink   (input valid, velocity_x, velocity_y, speed, arrived, output ready);
endinterface

interface asv_cfg_if import asv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RAD_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/arrive_steering_velocity_unit.sv
// Arrive steering unit top level: distance, speed ramp and scaled velocity.
// Depends on asv_pkg, asv_if, asv_sqrt_cell, asv_div_cell.
//
//   channel  dir  modport  carries
//   agents   in   sink     agent_x, agent_y, goal_x, goal_y
//   steer    out  source   velocity_x, velocity_y, speed, arrived
//   cfg      in   sink     index, data (target_radius, outer_radius, max_speed)
//
// One request per cycle while the skid register is empty; results pass through the
// 25-cell square root chain and the 23- and 24-cell divider chains.
// rst is synchronous and clears all valid bits and loads the register defaults.
// A full skid register holds the whole chain; agents.ready is that register's empty flag.
`timescale 1ns / 1ps

module arrive_steering_velocity_unit import asv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  asv_in_if.sink     agents,
  asv_out_if.source  steer,
  asv_cfg_if.sink    cfg
);

  localparam int SQ_SW = $bits(sq_side_t);
  localparam int RD_SW = $bits(rd_side_t);
  localparam int VX_SW = $bits(vx_side_t);
  localparam int RD_QW = NUM_W - RAD_W;
  localparam int V_LOW = PROD_W - VQ_W;

  logic [RAD_W-1:0] target_radius;
  logic [RAD_W-1:0] outer_radius;
  logic [RAD_W-1:0] max_speed;

  logic en;
  logic skid_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_radius <= TARGET_RADIUS_RST;
      outer_radius  <= OUTER_RADIUS_RST;
      max_speed     <= MAX_SPEED_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TARGET_RADIUS: target_radius <= cfg.data;
        REG_OUTER_RADIUS:  outer_radius  <= cfg.data;
        REG_MAX_SPEED:     max_speed     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en           = !skid_valid;
  assign agents.ready = en;

  // difference, magnitude, squares, sum
  logic              a_v, b_v, c_v, d_v;
  logic [DIFF_W-1:0] dx, dy;
  sq_side_t          b_side, c_side, d_side;
  logic [2*MAG_W-1:0] sqx, sqy;
  logic [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      a_v <= agents.valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {agents.goal_x[POS_W-1], agents.goal_x} - {agents.agent_x[POS_W-1], agents.agent_x};
      dy <= {agents.goal_y[POS_W-1], agents.goal_y} - {agents.agent_y[POS_W-1], agents.agent_y};
      b_side.sx <= dx[DIFF_W-1];
      b_side.sy <= dy[DIFF_W-1];
      b_side.ax <= dx[DIFF_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      b_side.ay <= dy[DIFF_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      sqx    <= b_side.ax * b_side.ax;
      sqy    <= b_side.ay * b_side.ay;
      c_side <= b_side;
      sum    <= {1'b0, sqx} + {1'b0, sqy};
      d_side <= c_side;
    end
  end

  // square root chain
  logic               sq_v    [0:DIST_W];
  logic [SQ_W-1:0]    sq_n    [0:DIST_W];
  logic [DIST_W-1:0]  sq_root [0:DIST_W];
  logic [SQREM_W-1:0] sq_rem  [0:DIST_W];
  logic [SQ_SW-1:0]   sq_side [0:DIST_W];

  assign sq_v[0]    = d_v;
  assign sq_n[0]    = SQ_W'(sum);
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = d_side;

  for (genvar i = 0; i < DIST_W; i++) begin : g_sqrt
    asv_sqrt_cell #(.NW(SQ_W), .RW(DIST_W), .REMW(SQREM_W), .SW(SQ_SW)) u_cell (
      .clk, .rst, .en,
      .vi(sq_v[i]), .n_i(sq_n[i]), .root_i(sq_root[i]), .rem_i(sq_rem[i]),
      .side_i(sq_side[i]),
      .vo(sq_v[i+1]), .n_o(sq_n[i+1]), .root_o(sq_root[i+1]), .rem_o(sq_rem[i+1]),
      .side_o(sq_side[i+1])
    );
  end

  // radius compare and ramp numerator
  sq_side_t          sq_last;
  logic [DIST_W-1:0] dlen;
  logic              e_v, f_v;
  rd_side_t          e_side, f_side;
  logic [RAD_W-1:0]  diff, span, f_span;
  logic [NUM_W-1:0]  num;

  assign sq_last = sq_side[DIST_W];
  assign dlen    = sq_root[DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
    end else if (en) begin
      e_v <= sq_v[DIST_W];
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side.arrived <= dlen <= DIST_W'(target_radius);
      e_side.full    <= dlen >= DIST_W'(outer_radius);
      e_side.sx      <= sq_last.sx;
      e_side.sy      <= sq_last.sy;
      e_side.ax      <= sq_last.ax;
      e_side.ay      <= sq_last.ay;
      e_side.dlen    <= dlen;
      diff   <= dlen[RAD_W-1:0] - target_radius;
      span   <= outer_radius - target_radius;
      num    <= diff * max_speed;
      f_span <= span;
      f_side <= e_side;
    end
  end

  // ramp divider chain
  logic             rd_v    [0:RD_QW];
  logic [RAD_W-1:0] rd_rem  [0:RD_QW];
  logic [RD_QW-1:0] rd_low  [0:RD_QW];
  logic [RD_QW-1:0] rd_q    [0:RD_QW];
  logic [RAD_W-1:0] rd_d    [0:RD_QW];
  logic [RD_SW-1:0] rd_side [0:RD_QW];

  assign rd_v[0]    = f_v;
  assign rd_rem[0]  = num[NUM_W-1 -: RAD_W];
  assign rd_low[0]  = num[RD_QW-1:0];
  assign rd_q[0]    = '0;
  assign rd_d[0]    = f_span;
  assign rd_side[0] = f_side;

  for (genvar i = 0; i < RD_QW; i++) begin : g_ramp
    asv_div_cell #(.DW(RAD_W), .NW(RD_QW), .QW(RD_QW), .SW(RD_SW)) u_cell (
      .clk, .rst, .en,
      .vi(rd_v[i]), .rem_i(rd_rem[i]), .low_i(rd_low[i]), .q_i(rd_q[i]),
      .d_i(rd_d[i]), .side_i(rd_side[i]),
      .vo(rd_v[i+1]), .rem_o(rd_rem[i+1]), .low_o(rd_low[i+1]), .q_o(rd_q[i+1]),
      .d_o(rd_d[i+1]), .side_o(rd_side[i+1])
    );
  end

  // speed select, component products, rounding offset
  rd_side_t          rd_last;
  logic              g_v, h_v, i_v;
  rd_side_t          g_side;
  logic [RAD_W-1:0]  g_spd, h_spd, i_spd;
  logic [PROD_W-2:0] px, py;
  logic [DIST_W-2:0] half;
  logic [DIST_W-1:0] h_dist, i_dist;
  logic              h_arr, h_sx, h_sy, i_arr, i_sx, i_sy;
  logic [PROD_W-1:0] nx, ny;

  assign rd_last = rd_side[RD_QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
    end else if (en) begin
      g_v <= rd_v[RD_QW];
      h_v <= g_v;
      i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_side <= rd_last;
      priority if (rd_last.arrived) begin
        g_spd <= '0;
      end else if (rd_last.full) begin
        g_spd <= max_speed;
      end else begin
        g_spd <= rd_q[RD_QW][RAD_W-1:0];
      end
      px     <= g_side.ax * g_spd;
      py     <= g_side.ay * g_spd;
      half   <= g_side.dlen[DIST_W-1:1];
      h_dist <= g_side.dlen;
      h_spd  <= g_spd;
      h_arr  <= g_side.arrived;
      h_sx   <= g_side.sx;
      h_sy   <= g_side.sy;
      nx     <= {1'b0, px} + PROD_W'(half);
      ny     <= {1'b0, py} + PROD_W'(half);
      i_dist <= h_dist;
      i_spd  <= h_spd;
      i_arr  <= h_arr;
      i_sx   <= h_sx;
      i_sy   <= h_sy;
    end
  end

  // component divider chains
  vx_side_t          i_side;
  logic              vx_v    [0:VQ_W];
  logic [DIST_W-1:0] vx_rem  [0:VQ_W];
  logic [V_LOW-1:0]  vx_low  [0:VQ_W];
  logic [VQ_W-1:0]   vx_q    [0:VQ_W];
  logic [DIST_W-1:0] vx_d    [0:VQ_W];
  logic [VX_SW-1:0]  vx_side [0:VQ_W];
  logic              vy_v    [0:VQ_W];
  logic [DIST_W-1:0] vy_rem  [0:VQ_W];
  logic [V_LOW-1:0]  vy_low  [0:VQ_W];
  logic [VQ_W-1:0]   vy_q    [0:VQ_W];
  logic [DIST_W-1:0] vy_d    [0:VQ_W];
  logic              vy_side [0:VQ_W];

  assign i_side.arrived = i_arr;
  assign i_side.sx      = i_sx;
  assign i_side.spd     = i_spd;

  assign vx_v[0]    = i_v;
  assign vx_rem[0]  = DIST_W'(nx[PROD_W-1 -: VQ_W]);
  assign vx_low[0]  = nx[V_LOW-1:0];
  assign vx_q[0]    = '0;
  assign vx_d[0]    = i_dist;
  assign vx_side[0] = i_side;
  assign vy_v[0]    = i_v;
  assign vy_rem[0]  = DIST_W'(ny[PROD_W-1 -: VQ_W]);
  assign vy_low[0]  = ny[V_LOW-1:0];
  assign vy_q[0]    = '0;
  assign vy_d[0]    = i_dist;
  assign vy_side[0] = i_sy;

  for (genvar i = 0; i < VQ_W; i++) begin : g_vel
    asv_div_cell #(.DW(DIST_W), .NW(V_LOW), .QW(VQ_W), .SW(VX_SW)) u_x (
      .clk, .rst, .en,
      .vi(vx_v[i]), .rem_i(vx_rem[i]), .low_i(vx_low[i]), .q_i(vx_q[i]),
      .d_i(vx_d[i]), .side_i(vx_side[i]),
      .vo(vx_v[i+1]), .rem_o(vx_rem[i+1]), .low_o(vx_low[i+1]), .q_o(vx_q[i+1]),
      .d_o(vx_d[i+1]), .side_o(vx_side[i+1])
    );
    asv_div_cell #(.DW(DIST_W), .NW(V_LOW), .QW(VQ_W), .SW(1)) u_y (
      .clk, .rst, .en,
      .vi(vy_v[i]), .rem_i(vy_rem[i]), .low_i(vy_low[i]), .q_i(vy_q[i]),
      .d_i(vy_d[i]), .side_i(vy_side[i]),
      .vo(vy_v[i+1]), .rem_o(vy_rem[i+1]), .low_o(vy_low[i+1]), .q_o(vy_q[i+1]),
      .d_o(vy_d[i+1]), .side_o(vy_side[i+1])
    );
  end

  function automatic logic [POS_W-1:0] sign_sat(input logic neg, input logic [VQ_W-1:0] q);
    logic [POS_W-1:0] r;
    if (!neg) begin
      r = (q > VEL_MAX) ? VEL_MAX : q;
    end else begin
      r = (q > VEL_MIN) ? VEL_MIN : POS_W'(-q);
    end
    return r;
  endfunction

  // result assembly, output register and skid
  vx_side_t         v_last;
  logic             push;
  logic [POS_W-1:0] res_vx, res_vy;
  logic [POS_W-1:0] skid_vx, skid_vy;
  logic [RAD_W-1:0] skid_spd;
  logic             skid_arr;

  assign v_last = vx_side[VQ_W];
  assign push   = en && vx_v[VQ_W] && vy_v[VQ_W];
  assign res_vx = v_last.arrived ? '0 : sign_sat(v_last.sx, vx_q[VQ_W]);
  assign res_vy = v_last.arrived ? '0 : sign_sat(vy_side[VQ_W], vy_q[VQ_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      steer.valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (steer.valid && !steer.ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      steer.valid <= 1'b1;
      skid_valid  <= 1'b0;
    end else begin
      steer.valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (steer.valid && !steer.ready) begin
      if (push) begin
        skid_vx  <= res_vx;
        skid_vy  <= res_vy;
        skid_spd <= v_last.spd;
        skid_arr <= v_last.arrived;
      end
    end else if (skid_valid) begin
      steer.velocity_x <= skid_vx;
      steer.velocity_y <= skid_vy;
      steer.speed      <= skid_spd;
      steer.arrived    <= skid_arr;
    end else begin
      steer.velocity_x <= res_vx;
      steer.velocity_y <= res_vy;
      steer.speed      <= v_last.spd;
      steer.arrived    <= v_last.arrived;
    end
  end

  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    steer.valid && steer.arrived |->
      steer.speed == '0 && steer.velocity_x == '0 && steer.velocity_y == '0)
    else $error("arrived result with nonzero motion");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> steer.valid)
    else $error("skid holds a result while the output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && steer.ready |=> steer.valid && !skid_valid)
    else $error("skid result not moved to output");

  a_chains_aligned: assert property (@(posedge clk) disable iff (rst)
    vx_v[VQ_W] == vy_v[VQ_W])
    else $error("velocity divider chains out of step");

endmodule

>>> hw/rtl/asv_sqrt_cell.sv
// One bit step of a pipelined restoring integer square root.
// No package dependencies.
`timescale 1ns / 1ps

module asv_sqrt_cell #(
  parameter int NW   = 50,
  parameter int RW   = 25,
  parameter int REMW = 27,
  parameter int SW   = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vi,
  input  logic [NW-1:0]   n_i,
  input  logic [RW-1:0]   root_i,
  input  logic [REMW-1:0] rem_i,
  input  logic [SW-1:0]   side_i,
  output logic            vo,
  output logic [NW-1:0]   n_o,
  output logic [RW-1:0]   root_o,
  output logic [REMW-1:0] rem_o,
  output logic [SW-1:0]   side_o
);

  logic [REMW+1:0] t;
  logic [REMW+1:0] trial;
  logic            ge;

  assign t     = {rem_i, n_i[NW-1 -: 2]};
  assign trial = (REMW+2)'({root_i, 2'b01});
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_o    <= {n_i[NW-3:0], 2'b00};
      root_o <= {root_i[RW-2:0], ge};
      rem_o  <= ge ? REMW'(t - trial) : REMW'(t);
      side_o <= side_i;
    end
  end

endmodule

>>> hw/rtl/asv_div_cell.sv
// One quotient bit step of a pipelined restoring divider.
// No package dependencies.
`timescale 1ns / 1ps

module asv_div_cell #(
  parameter int DW = 23,
  parameter int NW = 23,
  parameter int QW = 23,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vi,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] low_i,
  input  logic [QW-1:0] q_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] side_i,
  output logic          vo,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] low_o,
  output logic [QW-1:0] q_o,
  output logic [DW-1:0] d_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0] t;
  logic        ge;

  assign t  = {rem_i, low_i[NW-1]};
  assign ge = t >= {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? DW'(t - {1'b0, d_i}) : t[DW-1:0];
      low_o  <= {low_i[NW-2:0], 1'b0};
      q_o    <= {q_i[QW-2:0], ge};
      d_o    <= d_i;
      side_o <= side_i;
    end
  end

endmodule

>>> verif/tb.sv
// Self-checking bench for arrive_steering_velocity_unit: random and corner positions
// under several radius/speed settings, checked against a cycle-free predictor.
// Depends on asv_pkg and asv_if.
`timescale 1ns / 1ps

module tb;
  import asv_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [POS_W-1:0] vx;
    logic [POS_W-1:0] vy;
    logic [RAD_W-1:0] spd;
    logic             arr;
  } steer_t;

  class steer_scoreboard;
    steer_t pending[$];

    function void note(steer_t e);
      pending.push_back(e);
    endfunction

    function string check(steer_t got);
      steer_t e;
      string  msg;
      if (pending.size() == 0) return "steering result with no request outstanding";
      e   = pending.pop_front();
      msg = "";
      if (got.vx !== e.vx) msg = {msg, $sformatf(" vx %h/%h", got.vx, e.vx)};
      if (got.vy !== e.vy) msg = {msg, $sformatf(" vy %h/%h", got.vy, e.vy)};
      if (got.spd !== e.spd) msg = {msg, $sformatf(" speed %h/%h", got.spd, e.spd)};
      if (got.arr !== e.arr) msg = {msg, $sformatf(" arrived %b/%b", got.arr, e.arr)};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst;
  asv_in_if  agents ();
  asv_out_if steer ();
  asv_cfg_if cfg ();

  arrive_steering_velocity_unit dut (
    .clk    (clk),
    .rst    (rst),
    .agents (agents),
    .steer  (steer),
    .cfg    (cfg)
  );

  steer_scoreboard sb;
  int errors;
  int hold_left;
  logic [RAD_W-1:0] tgt_radius, out_radius, top_speed;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0t:%s", $realtime, msg);
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [POS_W-1:0] scale_axis(longint d, longint unsigned spd,
                                                   longint unsigned len);
    longint unsigned mag;
    longint          v;
    mag = (d < 0) ? -d : d;
    v   = longint'((mag * spd + len / 2) / len);
    if (d < 0) v = -v;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[POS_W-1:0];
  endfunction

  function automatic steer_t predict_steer(logic [POS_W-1:0] ax, ay, gx, gy);
    longint          dx, dy;
    longint unsigned mx, my, len, spd;
    steer_t          r;
    dx  = longint'($signed(gx)) - longint'($signed(ax));
    dy  = longint'($signed(gy)) - longint'($signed(ay));
    mx  = (dx < 0) ? -dx : dx;
    my  = (dy < 0) ? -dy : dy;
    len = int_sqrt(mx * mx + my * my);
    if (len <= tgt_radius) begin
      r = '{vx: '0, vy: '0, spd: '0, arr: 1'b1};
      return r;
    end
    if (len >= out_radius) spd = top_speed;
    else spd = ((len - tgt_radius) * top_speed) / (out_radius - tgt_radius);
    r.vx  = scale_axis(dx, spd, len);
    r.vy  = scale_axis(dy, spd, len);
    r.spd = spd[RAD_W-1:0];
    r.arr = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // output side: random back-pressure plus long hold-offs on request
  initial begin
    steer.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && steer.valid && steer.ready) begin
        string m;
        m = sb.check('{vx: steer.velocity_x, vy: steer.velocity_y,
                       spd: steer.speed, arr: steer.arrived});
        if (m != "") report(m);
      end
      if (hold_left > 0) begin
        hold_left--;
        steer.ready <= 1'b0;
      end else begin
        steer.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send_pos(logic [POS_W-1:0] ax, ay, gx, gy, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : pick_gap();
    if (g > 0) begin
      agents.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    agents.valid   <= 1'b1;
    agents.agent_x <= ax;
    agents.agent_y <= ay;
    agents.goal_x  <= gx;
    agents.goal_y  <= gy;
    do @(posedge clk); while (!agents.ready);
    sb.note(predict_steer(ax, ay, gx, gy));
  endtask

  task automatic quiesce();
    agents.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_RADIUS: tgt_radius = val;
      REG_OUTER_RADIUS:  out_radius = val;
      REG_MAX_SPEED:     top_speed  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [RAD_W-1:0] tr, orad, ms);
    quiesce();
    write_reg(REG_TARGET_RADIUS, tr);
    write_reg(REG_OUTER_RADIUS, orad);
    write_reg(REG_MAX_SPEED, ms);
  endtask

  task automatic send_random(bit no_gap = 0);
    logic [POS_W-1:0] ax, ay, ox, oy;
    int span;
    ax = POS_W'($urandom());
    ay = POS_W'($urandom());
    case ($urandom_range(0, 3))
      0: begin
        ox = POS_W'($urandom());
        oy = POS_W'($urandom());
      end
      default: begin
        span = int'(out_radius) + 600;
        if (span > 4000000) span = 4000000;
        ox = POS_W'($urandom_range(0, 2 * span) - span);
        oy = POS_W'($urandom_range(0, 2 * span) - span);
      end
    endcase
    send_pos(ax, ay, ax + ox, ay + oy, no_gap);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        hold_left = 400;
        for (int k = 0; k < 100; k++) send_random(1);
      end else if (i == 2 * n / 3) begin
        agents.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_random();
    end
  endtask

  initial begin
    sb           = new();
    errors       = 0;
    hold_left    = 0;
    tgt_radius   = TARGET_RADIUS_RST;
    out_radius   = OUTER_RADIUS_RST;
    top_speed    = MAX_SPEED_RST;
    rst          = 1'b1;
    agents.valid = 1'b0;
    agents.agent_x = '0;
    agents.agent_y = '0;
    agents.goal_x  = '0;
    agents.goal_y  = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset registers
    send_pos(24'd0, 24'd0, 24'd0, 24'd0);
    send_pos(24'd100, 24'd100, 24'd356, 24'd100);
    send_pos(24'd0, 24'd0, 24'd257, 24'd0);
    send_pos(24'd0, 24'd0, 24'd0, -24'sd2560);
    send_pos(24'd0, 24'd0, 24'd1400, 24'd600);
    send_pos(24'd0, 24'd0, -24'sd1000, -24'sd900);
    send_pos(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
    send_pos(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
    send_pos(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
    send_pos(24'h7fffff, 24'd0, 24'h800000, 24'd3);
    send_pos(24'h123456, 24'hfedcba, 24'h123456, 24'hfedcba);
    random_phase(100);

    // saturation: top speed, zero radii, overshoot from floored distance
    set_config(23'd0, 23'd0, 23'h7fffff);
    write_reg(REG_UNUSED, 23'h155555);
    send_pos(24'd0, 24'd0, 24'd0, 24'd0);
    send_pos(24'd0, 24'd0, 24'd1, 24'd1);
    send_pos(24'd0, 24'd0, 24'd3, 24'd0);
    send_pos(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
    send_pos(24'd5, 24'd5, 24'd2, 24'd1);
    random_phase(100);

    // outer radius below target radius
    set_config(23'd5000, 23'd1000, 23'd3000);
    send_pos(24'd0, 24'd0, 24'd5000, 24'd0);
    send_pos(24'd0, 24'd0, 24'd5001, 24'd0);
    random_phase(100);

    // huge radii
    set_config(23'h7ffffe, 23'h7fffff, 23'h400000);
    send_pos(24'h800000, 24'd0, 24'h7fffff, 24'd0);
    random_phase(80);

    // wide ramp
    set_config(23'd300, 23'd2000000, 23'd1000000);
    random_phase(100);

    set_config(RAD_W'($urandom_range(0, 4000)), RAD_W'($urandom_range(0, 40000)),
               RAD_W'($urandom()));
    random_phase(100);

    agents.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
